>>> hw/rtl/frc_pkg.sv
`timescale 1ns / 1ps

package frc_pkg;

  localparam int MAX_DIM   = 128;
  localparam int MEM_WORDS = 16384;

  localparam int COORD_W  = 12;
  localparam int CFG_W    = 12;
  localparam int REG_IDX_W = 3;
  localparam int CANVAS_W = 8;
  localparam int STRIDE_W = 8;
  localparam int COLOR_W  = 24;
  localparam int WORD_W   = 32;
  localparam int CNT_W    = 17;
  localparam int CALC_W   = 16;
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int MEM_AW   = $clog2(MEM_WORDS);
  localparam int ADDR_W   = DIM_W + STRIDE_W + 1;

  localparam int OUTLINE_SIDES = 4;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef enum logic [1:0] {
    OP_PUT     = 2'd0,
    OP_FILL    = 2'd1,
    OP_OUTLINE = 2'd2,
    OP_READ    = 2'd3
  } opcode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CANVAS_W  = 3'd0,
    REG_CANVAS_H  = 3'd1,
    REG_STRIDE    = 3'd2,
    REG_ORIGIN_X  = 3'd3,
    REG_ORIGIN_Y  = 3'd4,
    REG_BGRA      = 3'd5,
    REG_TARGET_EN = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic       clear_step;
    logic       cmd_load;
    logic       bounds_load;
    logic       scan_step;
    logic       rd_capture;
    logic       publish;
    logic [1:0] rect_idx;
  } frc_cmd_t;

  typedef struct packed {
    logic    clear_last;
    logic    rect_empty;
    logic    scan_last;
    opcode_e op;
  } frc_stat_t;

endpackage

>>> hw/rtl/frc_datapath.sv
`timescale 1ns / 1ps

module frc_datapath import frc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [REG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_data_i,
  input  logic [1:0]                  opcode_i,
  input  logic signed [COORD_W-1:0]   pos_x_i,
  input  logic signed [COORD_W-1:0]   pos_y_i,
  input  logic signed [COORD_W-1:0]   rect_w_i,
  input  logic signed [COORD_W-1:0]   rect_h_i,
  input  logic [COLOR_W-1:0]          color_rgb_i,
  input  logic signed [COORD_W-1:0]   thickness_i,
  input  frc_cmd_t                    cmd_i,
  output frc_stat_t                   stat_o,
  output logic [WORD_W-1:0]           pixel_word_o,
  output logic [CNT_W-1:0]            pixels_written_o
);

  function automatic logic signed [CALC_W-1:0] sext(logic signed [COORD_W-1:0] v);
    return {{(CALC_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(logic signed [CALC_W-1:0] v,
                                                 logic signed [CALC_W-1:0] d);
    logic signed [CALC_W-1:0] r;
    r = (v < 0) ? '0 : ((v > d) ? d : v);
    return r[DIM_W-1:0];
  endfunction

  logic [CANVAS_W-1:0]        canvas_w_q, canvas_h_q;
  logic [STRIDE_W-1:0]        stride_q;
  logic signed [COORD_W-1:0]  origin_x_q, origin_y_q;
  logic                       bgra_q, target_en_q;

  opcode_e                    op_q;
  logic signed [COORD_W-1:0]  x_q, y_q, w_q, h_q, t_q;
  logic [WORD_W-1:0]          color_q;

  logic [DIM_W-1:0]           x0_q, x1_q, y1_q, xx_q, yy_q;
  logic                       empty_q;
  logic [MEM_AW-1:0]          clr_q;
  logic [CNT_W-1:0]           count_q, count_out_q;
  logic [WORD_W-1:0]          word_acc_q, pixel_word_q;
  logic [WORD_W-1:0]          rd_data_q;
  logic                       rd_ok_q;
  logic [WORD_W-1:0]          frame_mem_q [MEM_WORDS];

  logic signed [CALC_W-1:0]   bx, by, rw, rh, ox, oy, sx0, sy0, ex1, ey1, wd, ht;
  logic [DIM_W-1:0]           cx0, cx1, cy0, cy1, xx_nx, yy_nx;
  logic                       empty_d;
  logic [ADDR_W-1:0]          scan_addr;
  logic                       in_range, scan_we, mem_we;
  logic [MEM_AW-1:0]          mem_addr;
  logic [WORD_W-1:0]          mem_wdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q  <= '0;
      canvas_h_q  <= '0;
      stride_q    <= '0;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      bgra_q      <= 1'b0;
      target_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CANVAS_W:  canvas_w_q  <= cfg_data_i[CANVAS_W-1:0];
        REG_CANVAS_H:  canvas_h_q  <= cfg_data_i[CANVAS_W-1:0];
        REG_STRIDE:    stride_q    <= cfg_data_i[STRIDE_W-1:0];
        REG_ORIGIN_X:  origin_x_q  <= cfg_data_i[COORD_W-1:0];
        REG_ORIGIN_Y:  origin_y_q  <= cfg_data_i[COORD_W-1:0];
        REG_BGRA:      bgra_q      <= cfg_data_i[0];
        REG_TARGET_EN: target_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Rectangle operands (current side for an outline) and clipped bounds
  always_comb begin
    bx = sext(x_q);
    by = sext(y_q);
    rw = sext(w_q);
    rh = sext(h_q);
    case (op_q) inside
      OP_PUT, OP_READ: begin
        rw = CALC_W'(1);
        rh = CALC_W'(1);
      end
      OP_OUTLINE: begin
        case (cmd_i.rect_idx)
          2'd0: rh = sext(t_q);
          2'd1: begin
            by = sext(y_q) + sext(h_q) - sext(t_q);
            rh = sext(t_q);
          end
          2'd2: rw = sext(t_q);
          default: begin
            bx = sext(x_q) + sext(w_q) - sext(t_q);
            rw = sext(t_q);
          end
        endcase
      end
      default: ;
    endcase
    ox  = sext(origin_x_q);
    oy  = sext(origin_y_q);
    wd  = ({{(CALC_W-CANVAS_W){1'b0}}, canvas_w_q} > CALC_W'(MAX_DIM)) ?
          CALC_W'(MAX_DIM) : {{(CALC_W-CANVAS_W){1'b0}}, canvas_w_q};
    ht  = ({{(CALC_W-CANVAS_W){1'b0}}, canvas_h_q} > CALC_W'(MAX_DIM)) ?
          CALC_W'(MAX_DIM) : {{(CALC_W-CANVAS_W){1'b0}}, canvas_h_q};
    sx0 = bx - ox;
    sy0 = by - oy;
    ex1 = sx0 + rw;
    ey1 = sy0 + rh;
    cx0 = clamp_dim(sx0, wd);
    cx1 = clamp_dim(ex1, wd);
    cy0 = clamp_dim(sy0, ht);
    cy1 = clamp_dim(ey1, ht);
    empty_d = !target_en_q || (rw <= 0) || (rh <= 0) || (cx0 >= cx1) || (cy0 >= cy1);
  end

  assign xx_nx     = xx_q + DIM_W'(1);
  assign yy_nx     = yy_q + DIM_W'(1);
  assign scan_addr = ADDR_W'(yy_q) * ADDR_W'(stride_q) + ADDR_W'(xx_q);
  assign in_range  = scan_addr < ADDR_W'(MEM_WORDS);
  assign scan_we   = cmd_i.scan_step && !empty_q && (op_q != OP_READ) && in_range;
  assign mem_we    = cmd_i.clear_step || scan_we;
  assign mem_addr  = cmd_i.clear_step ? clr_q : scan_addr[MEM_AW-1:0];
  assign mem_wdata = cmd_i.clear_step ? '0 : color_q;

  // Command latch and scan state
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd_load) begin
      op_q    <= opcode_e'(opcode_i);
      x_q     <= pos_x_i;
      y_q     <= pos_y_i;
      w_q     <= rect_w_i;
      h_q     <= rect_h_i;
      t_q     <= thickness_i;
      color_q <= bgra_q ?
                 {ALPHA_OPAQUE, color_rgb_i[7:0], color_rgb_i[15:8], color_rgb_i[23:16]} :
                 {ALPHA_OPAQUE, color_rgb_i};
    end
    if (cmd_i.bounds_load) begin
      x0_q    <= cx0;
      x1_q    <= cx1;
      y1_q    <= cy1;
      xx_q    <= cx0;
      yy_q    <= cy0;
      empty_q <= empty_d;
    end else if (cmd_i.scan_step) begin
      if (xx_nx == x1_q) begin
        xx_q <= x0_q;
        yy_q <= yy_nx;
      end else begin
        xx_q <= xx_nx;
      end
    end
    if (cmd_i.cmd_load) begin
      count_q    <= '0;
      word_acc_q <= '0;
    end else begin
      if (scan_we) count_q <= count_q + CNT_W'(1);
      if (cmd_i.rd_capture) word_acc_q <= rd_ok_q ? rd_data_q : '0;
    end
    if (cmd_i.publish) begin
      pixel_word_q <= word_acc_q;
      count_out_q  <= count_q;
    end
  end

  // Frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) frame_mem_q[mem_addr] <= mem_wdata;
    rd_data_q <= frame_mem_q[mem_addr];
    rd_ok_q   <= in_range && !empty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + MEM_AW'(1);
    end
  end

  assign stat_o.clear_last = (clr_q == MEM_AW'(MEM_WORDS - 1));
  assign stat_o.rect_empty = empty_q;
  assign stat_o.scan_last  = (xx_nx == x1_q) && (yy_nx == y1_q);
  assign stat_o.op         = op_q;

  assign pixel_word_o     = pixel_word_q;
  assign pixels_written_o = count_out_q;

endmodule

>>> hw/rtl/frc_controller.sv
`timescale 1ns / 1ps

module frc_controller import frc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  frc_stat_t stat_i,
  output frc_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_RDWAIT,
    S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] rect_idx_q, rect_idx_d;
  logic       out_valid_q, out_valid_d;
  logic       rect_done;

  assign rect_done = stat_i.rect_empty || stat_i.scan_last;

  always_comb begin
    state_d       = state_q;
    rect_idx_d    = rect_idx_q;
    cmd_o         = '0;
    cmd_o.rect_idx = rect_idx_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cmd_load = 1'b1;
          rect_idx_d     = '0;
          state_d        = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.bounds_load = 1'b1;
        state_d           = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = !stat_i.rect_empty;
        if (rect_done) begin
          if (stat_i.op == OP_OUTLINE && rect_idx_q != 2'(OUTLINE_SIDES - 1)) begin
            rect_idx_d = rect_idx_q + 2'd1;
            state_d    = S_SETUP;
          end else if (stat_i.op == OP_READ && !stat_i.rect_empty) begin
            state_d = S_RDWAIT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RDWAIT: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.publish ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rect_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rect_idx_q  <= rect_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/clipped_rect_fill_engine.sv
`timescale 1ns / 1ps
// Clipped rectangle fill engine over an internal 16384-word frame store.
// Input channel (in_valid_i/in_ready_o) takes one drawing command per item:
// put pixel, fill rect, outline rect (four fills) or read pixel.
// Output channel (out_valid_o/out_ready_i) returns one item per command:
// the stored word for a read (zero otherwise) and the number of writes made.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// After reset a clearing pass zeroes the store one word per cycle
// with in_ready_o low; configuration writes are taken meanwhile.
// Per command: a setup state, then a scan of the clipped area for each
// rectangle (outline: four rectangles), a read-wait state for a read that
// hits the window, then the output register.
// The scan steps one pixel per cycle and writes it through the single store
// port when its address lies in the store.
// One command is in work at a time; a new item is accepted while a result
// waits in the output register. If the receiver stalls, the next result
// holds inside the engine until the output register is free.
module clipped_rect_fill_engine import frc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                opcode_i,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] rect_w_i,
  input  logic signed [COORD_W-1:0] rect_h_i,
  input  logic [COLOR_W-1:0]        color_rgb_i,
  input  logic signed [COORD_W-1:0] thickness_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [WORD_W-1:0]         pixel_word_o,
  output logic [CNT_W-1:0]          pixels_written_o
);

  frc_cmd_t  cmd;
  frc_stat_t stat;

  frc_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  frc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .rect_w_i        (rect_w_i),
    .rect_h_i        (rect_h_i),
    .color_rgb_i     (color_rgb_i),
    .thickness_i     (thickness_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .pixel_word_o    (pixel_word_o),
    .pixels_written_o(pixels_written_o)
  );

endmodule

>>> hw/rtl/frc_checker.sv
`timescale 1ns / 1ps

module frc_checker import frc_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [WORD_W-1:0]         pixel_word_o,
  input logic [CNT_W-1:0]          pixels_written_o
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(pixel_word_o) && $stable(pixels_written_o))
    else $error("result item changed while stalled");

  // A read never writes; other commands return a zero word
  a_read_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_word_o != '0 |-> pixels_written_o == '0)
    else $error("nonzero word with writes");

  // Stored words are zero or opaque
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_word_o != '0 |-> pixel_word_o[31:24] == ALPHA_OPAQUE)
    else $error("read word without opaque alpha");

  // Write count bounded by four full-window sides
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pixels_written_o <= CNT_W'(OUTLINE_SIDES * MAX_DIM * MAX_DIM))
    else $error("write count out of range");

  // Not ready when reset is released, as the clearing pass begins
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("ready during clearing pass");

endmodule

bind clipped_rect_fill_engine frc_checker u_frc_checker (.*);

>>> verif/frc_draw_monitor.sv
`timescale 1ns / 1ps

module frc_draw_monitor import frc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [1:0]                opcode_i,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] rect_w_i,
  input  logic signed [COORD_W-1:0] rect_h_i,
  input  logic [COLOR_W-1:0]        color_rgb_i,
  input  logic signed [COORD_W-1:0] thickness_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [WORD_W-1:0]         pixel_word_i,
  input  logic [CNT_W-1:0]          pixels_written_i,
  input  logic                      done_i,
  output int                        pending_o,
  output int                        fail_count_o
);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  count;
  } draw_result_t;

  bit [WORD_W-1:0] shadow_fb [MEM_WORDS];
  draw_result_t    predicted_q [$];

  logic [CANVAS_W-1:0]       win_w;
  logic [CANVAS_W-1:0]       win_h;
  logic [STRIDE_W-1:0]       stride;
  logic signed [COORD_W-1:0] org_x;
  logic signed [COORD_W-1:0] org_y;
  logic                      bgr_swap;
  logic                      target_en;
  int                        result_no;
  bit                        leftover_checked;

  task automatic report_error(string msg);
    $display("ERROR: %s", msg);
    fail_count_o++;
  endtask

  function automatic int clip_dim(logic [CANVAS_W-1:0] d);
    return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] pack_pixel(logic [COLOR_W-1:0] c);
    if (bgr_swap) return {ALPHA_OPAQUE, c[7:0], c[15:8], c[23:16]};
    return {ALPHA_OPAQUE, c};
  endfunction

  function automatic int unsigned plot(int x, int y, logic [WORD_W-1:0] word);
    int addr;
    addr = y * int'(stride) + x;
    if (addr < 0 || addr >= MEM_WORDS) return 0;
    shadow_fb[addr] = word;
    return 1;
  endfunction

  function automatic int unsigned fill_clipped(int x, int y, int w, int h,
                                               logic [WORD_W-1:0] word);
    int x0, y0, x1, y1;
    int unsigned n;
    n = 0;
    if (!target_en || w <= 0 || h <= 0) return 0;
    x0 = clamp_int(x - int'(org_x), 0, clip_dim(win_w));
    y0 = clamp_int(y - int'(org_y), 0, clip_dim(win_h));
    x1 = clamp_int(x + w - int'(org_x), 0, clip_dim(win_w));
    y1 = clamp_int(y + h - int'(org_y), 0, clip_dim(win_h));
    for (int yy = y0; yy < y1; yy++)
      for (int xx = x0; xx < x1; xx++)
        n += plot(xx, yy, word);
    return n;
  endfunction

  function automatic draw_result_t predict_draw(opcode_e op, int x, int y, int w, int h,
                                                logic [COLOR_W-1:0] c, int t);
    draw_result_t      r;
    logic [WORD_W-1:0] word;
    int                px, py, addr;
    bit                in_win;
    int unsigned       n;
    word   = pack_pixel(c);
    px     = x - int'(org_x);
    py     = y - int'(org_y);
    in_win = px >= 0 && py >= 0 && px < clip_dim(win_w) && py < clip_dim(win_h);
    n      = 0;
    r.word = '0;
    case (op)
      OP_PUT: begin
        if (target_en && in_win) n = plot(px, py, word);
      end
      OP_FILL: begin
        n = fill_clipped(x, y, w, h, word);
      end
      OP_OUTLINE: begin
        if (t > 0) begin
          n = fill_clipped(x, y, w, t, word);
          n += fill_clipped(x, y + h - t, w, t, word);
          n += fill_clipped(x, y, t, h, word);
          n += fill_clipped(x + w - t, y, t, h, word);
        end
      end
      default: begin
        if (target_en && in_win) begin
          addr = py * int'(stride) + px;
          if (addr < MEM_WORDS) r.word = shadow_fb[addr];
        end
      end
    endcase
    r.count = n[CNT_W-1:0];
    return r;
  endfunction

  always @(negedge clk_i) begin : observe
    draw_result_t want;
    if (!rst_ni) begin
      win_w     = '0;
      win_h     = '0;
      stride    = '0;
      org_x     = '0;
      org_y     = '0;
      bgr_swap  = 1'b0;
      target_en = 1'b0;
      predicted_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CANVAS_W:  win_w     = cfg_data_i[CANVAS_W-1:0];
          REG_CANVAS_H:  win_h     = cfg_data_i[CANVAS_W-1:0];
          REG_STRIDE:    stride    = cfg_data_i[STRIDE_W-1:0];
          REG_ORIGIN_X:  org_x     = cfg_data_i[COORD_W-1:0];
          REG_ORIGIN_Y:  org_y     = cfg_data_i[COORD_W-1:0];
          REG_BGRA:      bgr_swap  = cfg_data_i[0];
          REG_TARGET_EN: target_en = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predicted_q.push_back(predict_draw(opcode_e'(opcode_i), int'(pos_x_i), int'(pos_y_i),
                                           int'(rect_w_i), int'(rect_h_i), color_rgb_i,
                                           int'(thickness_i)));
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_q.size() == 0) begin
          report_error($sformatf("result %0d unexpected: word %h count %0d",
                                 result_no, pixel_word_i, pixels_written_i));
        end else begin
          want = predicted_q.pop_front();
          if (pixel_word_i !== want.word)
            report_error($sformatf("result %0d pixel_word %h, want %h",
                                   result_no, pixel_word_i, want.word));
          if (pixels_written_i !== want.count)
            report_error($sformatf("result %0d pixels_written %0d, want %0d",
                                   result_no, pixels_written_i, want.count));
        end
        result_no++;
      end
      if (done_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (predicted_q.size() != 0)
          report_error($sformatf("%0d results never arrived", predicted_q.size()));
      end
    end
    pending_o = predicted_q.size();
  end

endmodule

>>> verif/tb_clipped_rect_fill_engine.sv
`timescale 1ns / 1ps

module tb_clipped_rect_fill_engine;
  import frc_pkg::*;

  localparam int IDLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 56;
  localparam int NUM_REGS      = 7;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0]      cfg_idx   = '0;
  logic [CFG_W-1:0]          cfg_data  = '0;
  logic                      in_valid  = 1'b0;
  logic [1:0]                opcode    = '0;
  logic signed [COORD_W-1:0] pos_x     = '0;
  logic signed [COORD_W-1:0] pos_y     = '0;
  logic signed [COORD_W-1:0] rect_w    = '0;
  logic signed [COORD_W-1:0] rect_h    = '0;
  logic [COLOR_W-1:0]        color     = '0;
  logic signed [COORD_W-1:0] thickness = '0;
  logic                      out_ready = 1'b0;
  logic                      done      = 1'b0;
  logic                      in_ready;
  logic                      out_valid;
  logic [WORD_W-1:0]         pixel_word;
  logic [CNT_W-1:0]          pixels_written;
  int                        pending;
  int                        fail_count;

  bit no_gaps   = 1'b0;
  int win_w_cur = 0;
  int win_h_cur = 0;
  int org_x_cur = 0;
  int org_y_cur = 0;

  clipped_rect_fill_engine uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .opcode_i         (opcode),
    .pos_x_i          (pos_x),
    .pos_y_i          (pos_y),
    .rect_w_i         (rect_w),
    .rect_h_i         (rect_h),
    .color_rgb_i      (color),
    .thickness_i      (thickness),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .pixel_word_o     (pixel_word),
    .pixels_written_o (pixels_written)
  );

  frc_draw_monitor monitor (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .opcode_i         (opcode),
    .pos_x_i          (pos_x),
    .pos_y_i          (pos_y),
    .rect_w_i         (rect_w),
    .rect_h_i         (rect_h),
    .color_rgb_i      (color),
    .thickness_i      (thickness),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .pixel_word_i     (pixel_word),
    .pixels_written_i (pixels_written),
    .done_i           (done),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic send_cmd(opcode_e op, int x, int y, int w, int h,
                          logic [COLOR_W-1:0] c, int t);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    pos_x     <= x[COORD_W-1:0];
    pos_y     <= y[COORD_W-1:0];
    rect_w    <= w[COORD_W-1:0];
    rect_h    <= h[COORD_W-1:0];
    color     <= c;
    thickness <= t[COORD_W-1:0];
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic program_regs(int cw, int ch, int st, int ox, int oy, bit bgr, bit en);
    logic [CFG_W-1:0] vals [NUM_REGS+1];
    vals[REG_CANVAS_W]  = cw[CFG_W-1:0];
    vals[REG_CANVAS_H]  = ch[CFG_W-1:0];
    vals[REG_STRIDE]    = st[CFG_W-1:0];
    vals[REG_ORIGIN_X]  = ox[CFG_W-1:0];
    vals[REG_ORIGIN_Y]  = oy[CFG_W-1:0];
    vals[REG_BGRA]      = {{(CFG_W-1){1'b0}}, bgr};
    vals[REG_TARGET_EN] = {{(CFG_W-1){1'b0}}, en};
    vals[REG_UNUSED]    = CFG_W'($urandom());
    cfg_we <= 1'b1;
    for (int i = 0; i <= NUM_REGS; i++) begin
      cfg_idx  <= i[REG_IDX_W-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    win_w_cur = (cw > MAX_DIM) ? MAX_DIM : cw;
    win_h_cur = (ch > MAX_DIM) ? MAX_DIM : ch;
    org_x_cur = ox;
    org_y_cur = oy;
  endtask

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(100, 255);
    return $urandom_range(1, 40);
  endfunction

  task automatic program_random();
    int cw, ch, st, ox, oy;
    cw = pick_dim();
    ch = pick_dim();
    st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : cw;
    ox = $urandom_range(0, 1) ? int'($urandom_range(0, 4095)) - 2048 : 0;
    oy = $urandom_range(0, 1) ? int'($urandom_range(0, 4095)) - 2048 : 0;
    program_regs(cw, ch, st, ox, oy, 1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
  endtask

  task automatic send_random_cmd();
    opcode_e            op;
    int                 x, y, w, h, t;
    logic [COLOR_W-1:0] c;
    op = opcode_e'($urandom_range(0, 3));
    c  = COLOR_W'($urandom());
    if ($urandom_range(0, 24) == 0) begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
      w = $urandom_range(0, 4095);
      h = $urandom_range(0, 4095);
      t = $urandom_range(0, 4095);
    end else begin
      x = org_x_cur + int'($urandom_range(0, win_w_cur + 15)) - 8;
      y = org_y_cur + int'($urandom_range(0, win_h_cur + 15)) - 8;
      w = int'($urandom_range(0, 22)) - 3;
      h = int'($urandom_range(0, 22)) - 3;
      t = int'($urandom_range(0, 7)) - 2;
    end
    send_cmd(op, x, y, w, h, c, t);
  endtask

  initial begin : drain_results
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        do @(negedge clk); while (!out_valid);
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // drawing disabled out of reset
    send_cmd(OP_PUT, 0, 0, 0, 0, 24'hffffff, 0);
    send_cmd(OP_FILL, 0, 0, 4, 4, 24'hffffff, 0);
    send_cmd(OP_OUTLINE, 0, 0, 4, 4, 24'hffffff, 1);
    send_cmd(OP_READ, 0, 0, 0, 0, 24'h000000, 0);

    // oversized window saturates
    wait_idle();
    program_regs(255, 255, 128, 0, 0, 1'b0, 1'b1);
    send_cmd(OP_PUT, 0, 0, 0, 0, 24'hffffff, 0);
    send_cmd(OP_PUT, 127, 127, 0, 0, 24'h123456, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 24'h000000, 0);
    send_cmd(OP_READ, 127, 127, 0, 0, 24'h000000, 0);
    send_cmd(OP_READ, 128, 5, 0, 0, 24'h000000, 0);
    send_cmd(OP_READ, -1, 0, 0, 0, 24'h000000, 0);
    send_cmd(OP_FILL, 3, 3, 0, 5, 24'h777777, 0);
    send_cmd(OP_FILL, 3, 3, 5, -2048, 24'h777777, 0);
    send_cmd(OP_OUTLINE, 0, 0, 10, 10, 24'h777777, 0);
    send_cmd(OP_OUTLINE, 0, 0, 10, 10, 24'h777777, -2048);
    send_cmd(OP_FILL, 0, 0, 2047, 2047, 24'h000000, 0);
    send_cmd(OP_OUTLINE, -10, -10, 2047, 2047, 24'ha5c3e1, 2047);
    send_cmd(OP_READ, 64, 64, 0, 0, 24'h000000, 0);

    // extreme origins, wide stride runs past the store
    wait_idle();
    program_regs(128, 128, 255, 2047, -2048, 1'b1, 1'b1);
    send_cmd(OP_PUT, 2047, -2048, 0, 0, 24'h102030, 0);
    send_cmd(OP_READ, 2047, -2048, 0, 0, 24'h000000, 0);
    send_cmd(OP_PUT, 2047, -1948, 0, 0, 24'hffffff, 0);
    send_cmd(OP_READ, 2047, -1948, 0, 0, 24'h000000, 0);
    send_cmd(OP_FILL, 2047, -1988, 20, 10, 24'h00ff00, 0);
    send_cmd(OP_OUTLINE, 2047, -2048, 8, 8, 24'h0000ff, 2);
    send_cmd(OP_PUT, -2048, 2047, 0, 0, 24'habcdef, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      no_gaps = (p % 4 == 3);
      program_random();
      repeat (PHASE_ITEMS) send_random_cmd();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/frc_pkg.sv
hw/rtl/frc_datapath.sv
hw/rtl/frc_controller.sv
hw/rtl/clipped_rect_fill_engine.sv
hw/rtl/frc_checker.sv
verif/frc_draw_monitor.sv
verif/tb_clipped_rect_fill_engine.sv
